/* design/trigger_step_sequencer_8x16_defines.svh */
// Assertion macros for the trigger step sequencer.
// Used by the top level only; no other dependencies.
`ifndef TRIGGER_STEP_SEQUENCER_8X16_DEFINES_SVH
`define TRIGGER_STEP_SEQUENCER_8X16_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define TSS_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define TSS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define TSS_ASSERT_NOW(name, ante, cons, msg)
`define TSS_ASSERT_NEXT(name, ante, cons, msg)
`endif

`endif

/* design/tss_pkg.sv */
// Shared types and constants for the trigger step sequencer.
// No dependencies.
package tss_pkg;

  localparam int ROWS       = 8;
  localparam int STEPS      = 16;
  localparam int PHASE_BITS = 32;
  localparam int STEP_BITS  = 4;
  localparam int COUNT_BITS = 5;
  localparam int CELL_BITS  = 7;
  localparam int ROW_BITS   = CELL_BITS - STEP_BITS;

  typedef struct packed {
    logic                  run_button;
    logic                  start_level;
    logic                  stop_level;
    logic                  ext_clock_connected;
    logic                  ext_clock_level;
    logic                  reset_level;
    logic [31:0]           phase_increment;
    logic [COUNT_BITS-1:0] step_count;
    logic [ROWS-1:0]       row_buttons;
    logic [STEPS-1:0]      column_buttons;
    logic                  toggle_valid;
    logic [CELL_BITS-1:0]  toggle_cell;
  } item_t;

  typedef struct packed {
    logic [ROWS-1:0]      gates;
    logic                 clock_pulse;
    logic [STEP_BITS-1:0] current_step;
    logic                 is_running;
  } result_t;

  // per-tick status from the timing block
  typedef struct packed {
    logic                 advance;
    logic                 pulse;
    logic [STEP_BITS-1:0] step;
    logic                 running;
  } timing_t;

endpackage

/* design/tss_timing.sv */
// Run flag, phase accumulator, step counter and their edge detectors.
// Depends on tss_pkg.
module tss_timing (
  input  logic            clk,
  input  logic            rst,
  input  logic            fire,
  input  tss_pkg::item_t  item,
  output tss_pkg::timing_t timing
);

  logic                                   run_flag, run_flag_next;
  logic [tss_pkg::PHASE_BITS-1:0]         phase_acc, phase_acc_next;
  logic [tss_pkg::STEP_BITS-1:0]          step_index, step_index_next;
  logic                                   prev_run, prev_ext, prev_ext_next, prev_rst;
  logic [tss_pkg::PHASE_BITS:0]           phase_sum;
  logic [tss_pkg::COUNT_BITS-1:0]         count_clamped;
  logic [tss_pkg::COUNT_BITS-1:0]         step_inc;
  logic                                   clk_advance;

  assign phase_sum = {1'b0, phase_acc}
                   + {1'b0, item.phase_increment[tss_pkg::PHASE_BITS-1:0]};
  assign step_inc  = tss_pkg::COUNT_BITS'(step_index) + tss_pkg::COUNT_BITS'(1);

  always_comb begin
    run_flag_next = run_flag ^ (item.run_button & ~prev_run);
    if (item.start_level) run_flag_next = 1'b1;
    if (item.stop_level) run_flag_next = 1'b0;

    phase_acc_next = phase_acc;
    prev_ext_next  = prev_ext;
    clk_advance    = 1'b0;
    if (run_flag_next) begin
      if (item.ext_clock_connected) begin
        prev_ext_next = item.ext_clock_level;
        if (item.ext_clock_level && !prev_ext) begin
          phase_acc_next = '0;
          clk_advance    = 1'b1;
        end
      end else begin
        phase_acc_next = phase_sum[tss_pkg::PHASE_BITS-1:0];
        clk_advance    = phase_sum[tss_pkg::PHASE_BITS];
      end
    end

    if (item.step_count == '0) begin
      count_clamped = tss_pkg::COUNT_BITS'(1);
    end else if (item.step_count > tss_pkg::COUNT_BITS'(tss_pkg::STEPS)) begin
      count_clamped = tss_pkg::COUNT_BITS'(tss_pkg::STEPS);
    end else begin
      count_clamped = item.step_count;
    end

    step_index_next = step_index;
    timing.advance  = clk_advance;
    if (item.reset_level && !prev_rst) begin
      phase_acc_next  = '0;
      step_index_next = '0;
      timing.advance  = 1'b1;
    end else if (clk_advance) begin
      step_index_next = (step_inc >= count_clamped) ? '0
                      : step_inc[tss_pkg::STEP_BITS-1:0];
    end

    timing.pulse   = clk_advance;
    timing.step    = step_index_next;
    timing.running = run_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_flag   <= 1'b1;
      phase_acc  <= '0;
      step_index <= '0;
      prev_run   <= 1'b0;
      prev_ext   <= 1'b0;
      prev_rst   <= 1'b0;
    end else if (fire) begin
      run_flag   <= run_flag_next;
      phase_acc  <= phase_acc_next;
      step_index <= step_index_next;
      prev_run   <= item.run_button;
      prev_ext   <= prev_ext_next;
      prev_rst   <= item.reset_level;
    end
  end

endmodule

/* design/tss_matrix.sv */
// Gate matrix with row, column and single-cell editing; reads one step column.
// Depends on tss_pkg.
module tss_matrix (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          fire,
  input  tss_pkg::item_t                item,
  input  logic [tss_pkg::STEP_BITS-1:0] step,
  output logic [tss_pkg::ROWS-1:0]      gates_raw
);

  logic [tss_pkg::STEPS-1:0] matrix [tss_pkg::ROWS];
  logic [tss_pkg::STEPS-1:0] matrix_next [tss_pkg::ROWS];
  logic [tss_pkg::ROWS-1:0]  row_full, row_full_next, prev_rows, row_edges;
  logic [tss_pkg::STEPS-1:0] col_full, col_full_next, prev_cols, col_edges;
  logic [tss_pkg::ROW_BITS-1:0]  cell_row;
  logic [tss_pkg::STEP_BITS-1:0] cell_col;

  assign row_edges     = item.row_buttons & ~prev_rows;
  assign col_edges     = item.column_buttons & ~prev_cols;
  assign row_full_next = row_full ^ row_edges;
  assign col_full_next = col_full ^ col_edges;
  assign cell_row      = item.toggle_cell[tss_pkg::CELL_BITS-1:tss_pkg::STEP_BITS];
  assign cell_col      = item.toggle_cell[tss_pkg::STEP_BITS-1:0];

  // rows, then columns, then the single cell; every cell code names a real row
  always_comb begin
    for (int z = 0; z < tss_pkg::ROWS; z++) begin
      matrix_next[z] = matrix[z];
      if (row_edges[z]) matrix_next[z] = row_full_next[z] ? '1 : '0;
      matrix_next[z] = (matrix_next[z] & ~col_edges) | (col_full_next & col_edges);
      if (item.toggle_valid && cell_row == tss_pkg::ROW_BITS'(z)) begin
        matrix_next[z][cell_col] = ~matrix_next[z][cell_col];
      end
      gates_raw[z] = matrix_next[z][step];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int z = 0; z < tss_pkg::ROWS; z++) matrix[z] <= '0;
      row_full  <= '0;
      col_full  <= '0;
      prev_rows <= '0;
      prev_cols <= '0;
    end else if (fire) begin
      for (int z = 0; z < tss_pkg::ROWS; z++) matrix[z] <= matrix_next[z];
      row_full  <= row_full_next;
      col_full  <= col_full_next;
      prev_rows <= item.row_buttons;
      prev_cols <= item.column_buttons;
    end
  end

endmodule

/* design/trigger_step_sequencer_8x16.sv */
// Top level of the 8 x 16 trigger step sequencer: input and result registers.
// Depends on tss_pkg, tss_timing, tss_matrix and the assertion macro header.
//
//   channel   valid          stall          payload
//   ------    ------------   ------------   ----------------------
//   in        item_valid     item_stall     item   (tss_pkg::item_t)
//   out       result_valid   result_stall   result (tss_pkg::result_t)
//
// One request per cycle sustained while result_stall is low; an accepted request
// passes the input register, then one pass of step logic, into the result register.
// Reset empties both registers and restores the sequencer state.
// A stalled result holds; the input register still takes one more request,
// after which item_stall rises until the result moves.
`include "trigger_step_sequencer_8x16_defines.svh"

module trigger_step_sequencer_8x16 (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  tss_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output tss_pkg::result_t result
);

  tss_pkg::item_t           held;
  logic                     held_valid;
  logic                     fire;
  tss_pkg::timing_t         timing;
  logic [tss_pkg::ROWS-1:0] gates_raw;

  assign fire       = held_valid && (!result_valid || !result_stall);
  assign item_stall = held_valid && !fire;

  tss_timing u_timing (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (held),
    .timing (timing)
  );

  tss_matrix u_matrix (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .item      (held),
    .step      (timing.step),
    .gates_raw (gates_raw)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (!item_stall) held_valid <= item_valid;
      if (fire) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
    if (item_valid && !item_stall) held <= item;
    if (fire) begin
      result.gates        <= timing.advance ? '0 : gates_raw;
      result.clock_pulse  <= timing.pulse;
      result.current_step <= timing.step;
      result.is_running   <= timing.running;
    end
  end

  `TSS_ASSERT_NOW(a_pulse_gates_low, result_valid && result.clock_pulse, result.gates == '0, "gates high on an advancing tick")
  `TSS_ASSERT_NOW(a_pulse_running, result_valid && result.clock_pulse, result.is_running, "clock pulse while stopped")
  `TSS_ASSERT_NEXT(a_held_moves, held_valid && !result_stall, result_valid, "held request not passed to result")

endmodule
